### design/stpwm_pkg.sv
// Shared widths, register codes and the period table of the slow time-proportioning PWM.
`timescale 1ns / 1ps

package stpwm_pkg;

   localparam int unsigned POWER_WIDTH     = 10;
   localparam int unsigned PHASE_WIDTH     = 16;
   localparam int unsigned SELECT_WIDTH    = 4;
   localparam int unsigned CSR_DATA_WIDTH  = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   // Number of valid period table entries; higher selections use the last one.
   localparam int unsigned PERIOD_COUNT = 10;
   // Default full-scale power in per mille.
   localparam int unsigned FULL_SCALE   = 1000;
   // Longest phase that the table can produce.
   localparam int unsigned PHASE_MAX    = 50000;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OUTPUT_MODE   = 2'd0,
      CSR_PERIOD_SELECT = 2'd1
   } csr_index_type;

   // Period in milliseconds for a selection, clamped to the valid entries.
   function automatic logic [PHASE_WIDTH-1:0] period_of(input logic [SELECT_WIDTH-1:0] sel);
      logic [SELECT_WIDTH-1:0] idx;
      logic [PHASE_WIDTH-1:0]  per;
      idx = sel;
      if (32'(sel) >= PERIOD_COUNT) begin
         idx = SELECT_WIDTH'(PERIOD_COUNT - 1);
      end
      case (idx)
         4'd0:    per = 16'd100;
         4'd1:    per = 16'd200;
         4'd2:    per = 16'd500;
         4'd3:    per = 16'd1000;
         4'd4:    per = 16'd2000;
         4'd5:    per = 16'd5000;
         4'd6:    per = 16'd10000;
         4'd7:    per = 16'd20000;
         4'd8:    per = 16'd50000;
         default: per = 16'd5;
      endcase
      return per;
   endfunction

endpackage

### design/slow_time_proportioning_pwm.sv
// Top level of the slow time-proportioning PWM: tick pipeline, phase counter and configuration.
//
//   Port group   Direction   Handshake             Contents
//   req_*        in          req_valid/req_ready   one tick with the present power
//   rsp_*        out         rsp_valid/rsp_ready   drive level and phase time left
//   csr_*        in          csr_write             register index and write data
//
// One request is taken every cycle while no held response backs up the pipeline.
// The datapath does the power times period multiply and the divide by full scale,
// done as a split reciprocal multiply with one correction step, in a pipeline of five stages.
// Reset is synchronous and needs no clearing pass.
// A held response stalls only the full stages behind it; empty stages still take requests.
`timescale 1ns / 1ps

module slow_time_proportioning_pwm #(
   parameter int unsigned FULL_SCALE = stpwm_pkg::FULL_SCALE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [stpwm_pkg::POWER_WIDTH-1:0]    req_power,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_drive,
   output logic [stpwm_pkg::PHASE_WIDTH-1:0]    rsp_phase_left,
   input  logic                                 csr_write,
   input  logic [stpwm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [stpwm_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   import stpwm_pkg::*;

   // Divide by full scale: floor(x * RECIP / 2^PROD_WIDTH) is the quotient or one below it.
   localparam int unsigned     PROD_WIDTH  = PHASE_WIDTH + POWER_WIDTH;
   localparam longint unsigned RECIP       = (64'd1 << PROD_WIDTH) / FULL_SCALE;
   localparam int unsigned     RECIP_WIDTH = $clog2(RECIP + 1);
   localparam int unsigned     LO_WIDTH    = PROD_WIDTH / 2;
   localparam int unsigned     HI_WIDTH    = PROD_WIDTH - LO_WIDTH;
   localparam int unsigned     SUM_WIDTH   = PROD_WIDTH + RECIP_WIDTH;

   localparam logic [RECIP_WIDTH-1:0] RECIP_VALUE = RECIP_WIDTH'(RECIP);
   localparam logic [POWER_WIDTH-1:0] FULL_POWER  = POWER_WIDTH'(FULL_SCALE);

   // Configuration and phase state.
   logic                    mode_ff;
   logic [SELECT_WIDTH-1:0] select_ff;
   logic                    level_ff;
   logic [PHASE_WIDTH-1:0]  remaining_ff;
   logic [PHASE_WIDTH-1:0]  interval_ff;
   logic [PHASE_WIDTH-1:0]  period;

   // Pipeline occupancy and load enables.
   logic [5:1] stage_valid_ff;
   logic [6:1] stage_load;

   // Stage registers.
   logic [POWER_WIDTH-1:0]          power_s1_ff;
   logic [POWER_WIDTH-1:0]          power_sat;
   logic [PROD_WIDTH-1:0]           prod_s2_ff;
   logic [PROD_WIDTH-1:0]           prod_in;
   logic [4:2]                      zero_ff;
   logic [4:2]                      full_ff;
   logic [PROD_WIDTH-1:0]           prod_s3_ff;
   logic [HI_WIDTH+RECIP_WIDTH-1:0] part_hi_ff;
   logic [HI_WIDTH+RECIP_WIDTH-1:0] part_hi_in;
   logic [LO_WIDTH+RECIP_WIDTH-1:0] part_lo_ff;
   logic [LO_WIDTH+RECIP_WIDTH-1:0] part_lo_in;
   logic [PROD_WIDTH-1:0]           prod_s4_ff;
   logic [SUM_WIDTH-1:0]            recip_sum;
   logic [PHASE_WIDTH-1:0]          quot_est_ff;
   logic [PHASE_WIDTH-1:0]          quot_est_in;
   logic [PROD_WIDTH-1:0]           quot_rem;
   logic [PHASE_WIDTH-1:0]          on_time_ff;
   logic [PHASE_WIDTH-1:0]          on_time_in;
   logic                            zero_s5_ff;
   logic                            full_s5_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_drive_ff;
   logic [PHASE_WIDTH-1:0] rsp_phase_ff;

   // Next state of the phase machine.
   logic [PHASE_WIDTH-1:0] off_time;
   logic                   level_in;
   logic [PHASE_WIDTH-1:0] remaining_in;
   logic [PHASE_WIDTH-1:0] interval_in;
   logic                   mode_in;
   logic [SELECT_WIDTH-1:0] select_in;
   logic                   restart;

   assign period = period_of(select_ff);

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      stage_load[6] = !rsp_valid_ff || rsp_ready;
      for (int k = 5; k >= 1; k--) begin
         stage_load[k] = !stage_valid_ff[k] || stage_load[k+1];
      end
   end

   assign req_ready = stage_load[1];

   // Saturate the requested power at full scale.
   assign power_sat = (req_power > FULL_POWER) ? FULL_POWER : req_power;

   // Datapath of the on-time calculation.
   assign prod_in     = PROD_WIDTH'(period) * PROD_WIDTH'(power_s1_ff);
   assign part_hi_in  = (HI_WIDTH+RECIP_WIDTH)'(prod_s2_ff[PROD_WIDTH-1:LO_WIDTH])
                        * (HI_WIDTH+RECIP_WIDTH)'(RECIP_VALUE);
   assign part_lo_in  = (LO_WIDTH+RECIP_WIDTH)'(prod_s2_ff[LO_WIDTH-1:0])
                        * (LO_WIDTH+RECIP_WIDTH)'(RECIP_VALUE);
   assign recip_sum   = (SUM_WIDTH'(part_hi_ff) << LO_WIDTH) + SUM_WIDTH'(part_lo_ff);
   assign quot_est_in = recip_sum[PROD_WIDTH +: PHASE_WIDTH];
   assign quot_rem    = prod_s4_ff - PROD_WIDTH'(quot_est_ff) * PROD_WIDTH'(FULL_SCALE);
   assign on_time_in  = quot_est_ff + PHASE_WIDTH'(quot_rem >= PROD_WIDTH'(FULL_SCALE));

   // Pipeline stages; payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         if (stage_load[1]) begin
            stage_valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= 5; k++) begin
            if (stage_load[k]) begin
               stage_valid_ff[k] <= stage_valid_ff[k-1];
            end
         end
      end
      if (stage_load[1]) begin
         power_s1_ff <= power_sat;
      end
      if (stage_load[2]) begin
         prod_s2_ff <= prod_in;
         zero_ff[2] <= (power_s1_ff == '0);
         full_ff[2] <= (power_s1_ff == FULL_POWER);
      end
      if (stage_load[3]) begin
         prod_s3_ff <= prod_s2_ff;
         part_hi_ff <= part_hi_in;
         part_lo_ff <= part_lo_in;
         zero_ff[3] <= zero_ff[2];
         full_ff[3] <= full_ff[2];
      end
      if (stage_load[4]) begin
         prod_s4_ff  <= prod_s3_ff;
         quot_est_ff <= quot_est_in;
         zero_ff[4]  <= zero_ff[3];
         full_ff[4]  <= full_ff[3];
      end
      if (stage_load[5]) begin
         on_time_ff <= on_time_in;
         zero_s5_ff <= zero_ff[4];
         full_s5_ff <= full_ff[4];
      end
   end

   // The off time is the full period less the on time.
   assign off_time = period - on_time_ff;

   // Phase machine and configuration writes.
   always_comb begin
      level_in     = level_ff;
      remaining_in = remaining_ff;
      interval_in  = interval_ff;
      mode_in      = mode_ff;
      select_in    = select_ff;
      restart      = 1'b0;
      if (stage_valid_ff[5] && stage_load[6]) begin
         if (!mode_ff) begin
            level_in = !zero_s5_ff;
         end else if (remaining_ff <= PHASE_WIDTH'(1)) begin
            if (level_ff) begin
               if (!full_s5_ff && off_time != '0) begin
                  level_in    = 1'b0;
                  interval_in = off_time;
               end
            end else begin
               if (!zero_s5_ff && on_time_ff != '0) begin
                  level_in    = 1'b1;
                  interval_in = on_time_ff;
               end
            end
            remaining_in = interval_in;
         end else begin
            remaining_in = remaining_ff - PHASE_WIDTH'(1);
         end
      end
      if (csr_write) begin
         case (csr_index)
            CSR_OUTPUT_MODE: begin
               mode_in = csr_wdata[0];
               restart = 1'b1;
            end
            CSR_PERIOD_SELECT: begin
               select_in = csr_wdata[SELECT_WIDTH-1:0];
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
      if (restart) begin
         level_in     = 1'b0;
         interval_in  = period_of(select_in);
         remaining_in = interval_in;
      end
   end

   // State and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         select_ff    <= '0;
         level_ff     <= 1'b0;
         interval_ff  <= period_of('0);
         remaining_ff <= period_of('0);
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         select_ff    <= select_in;
         level_ff     <= level_in;
         interval_ff  <= interval_in;
         remaining_ff <= remaining_in;
         if (stage_load[6]) begin
            rsp_valid_ff <= stage_valid_ff[5];
         end
      end
      if (stage_load[6]) begin
         rsp_drive_ff <= level_in;
         rsp_phase_ff <= mode_ff ? remaining_in : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive      = rsp_drive_ff;
   assign rsp_phase_left = rsp_phase_ff;

endmodule

### design/stpwm_checker.sv
// Port-level checks of the slow time-proportioning PWM and their binding to the top level.
`timescale 1ns / 1ps

module stpwm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [stpwm_pkg::POWER_WIDTH-1:0]    req_power,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_drive,
   input logic [stpwm_pkg::PHASE_WIDTH-1:0]    rsp_phase_left,
   input logic                                 csr_write,
   input logic [stpwm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [stpwm_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   import stpwm_pkg::*;

   logic mode_ff;
   logic unused_inputs;

   assign unused_inputs = req_valid ^ (^req_power);

   // Shadow of the output mode as written through the register port.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write && csr_index == CSR_OUTPUT_MODE) begin
         mode_ff <= csr_wdata[0];
      end
   end

   // A held response keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_phase_left))
      else $error("held response changed");

   // The pipeline is empty straight after reset and takes a request.
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("not ready after reset");

   // In on/off mode the phase time reads zero.
   a_onoff_phase: assert property (@(posedge clock) disable iff (reset || unused_inputs === 1'bx)
      rsp_valid && !mode_ff |-> rsp_phase_left == '0)
      else $error("phase time in on/off mode");

   // In proportional mode a phase is never empty and never longer than the longest period.
   a_prop_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mode_ff |-> rsp_phase_left != '0
                              && rsp_phase_left <= PHASE_WIDTH'(PHASE_MAX))
      else $error("phase time out of range");

endmodule

bind slow_time_proportioning_pwm stpwm_checker u_stpwm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_power      (req_power),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_drive      (rsp_drive),
   .rsp_phase_left (rsp_phase_left),
   .csr_write      (csr_write),
   .csr_index      (csr_index),
   .csr_wdata      (csr_wdata)
);

### dv/slow_time_proportioning_pwm_test.sv
// Self-checking testbench for the slow time-proportioning PWM, with its own tick predictor.
`timescale 1ns / 1ps

module slow_time_proportioning_pwm_test;

   localparam int unsigned POWER_W   = stpwm_pkg::POWER_WIDTH;
   localparam int unsigned PHASE_W   = stpwm_pkg::PHASE_WIDTH;
   localparam int unsigned SELECT_W  = stpwm_pkg::SELECT_WIDTH;
   localparam int unsigned CSR_IDX_W = stpwm_pkg::CSR_INDEX_WIDTH;
   localparam int unsigned CSR_DAT_W = stpwm_pkg::CSR_DATA_WIDTH;
   localparam int unsigned FULL      = stpwm_pkg::FULL_SCALE;

   // Register indexes with nothing behind them; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   localparam int unsigned RANDOM_TICKS  = 1100;
   localparam int unsigned HOLD_CYCLES   = 64;
   localparam int unsigned HOLD_AFTER    = 300;
   localparam int unsigned DRAIN_CYCLES  = 12;
   localparam int unsigned DIRECTED_ROWS = 27;
   localparam longint unsigned LIMIT_NS  = 2_000_000;

   typedef struct packed {
      logic               drive;
      logic [PHASE_W-1:0] phase_left;
   } pwm_result_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] data;
      logic [POWER_W-1:0]   power;
      logic                 typed;
      logic                 exp_drive;
      logic [PHASE_W-1:0]   exp_phase;
   } stim_row_type;

   // Directed requests and register writes; typed rows carry their own expected result.
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // On/off mode straight after reset: drive follows power, phase reads zero.
      '{ROW_TICK, 2'd0, 4'd0, 10'd0,    1'b1, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1023, 1'b1, 1'b1, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1,    1'b1, 1'b1, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1000, 1'b1, 1'b1, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd512,  1'b1, 1'b1, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd0,    1'b1, 1'b0, 16'd0},
      // Shortest period, proportional mode with the upper data bits set.
      '{ROW_CSR, stpwm_pkg::CSR_PERIOD_SELECT, 4'd9,  10'd0, 1'b0, 1'b0, 16'd0},
      '{ROW_CSR, stpwm_pkg::CSR_OUTPUT_MODE,   4'hF,  10'd0, 1'b0, 1'b0, 16'd0},
      // Saturated power: low for the restart period, then high and held.
      '{ROW_TICK, 2'd0, 4'd0, 10'd1023, 1'b1, 1'b0, 16'd4},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1023, 1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1023, 1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1023, 1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1023, 1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1000, 1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1000, 1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1000, 1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd1000, 1'b0, 1'b0, 16'd0},
      // Low power: the on time rounds to zero, so the level stays low once it drops.
      '{ROW_TICK, 2'd0, 4'd0, 10'd100,  1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd100,  1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd100,  1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd100,  1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd100,  1'b0, 1'b0, 16'd0},
      // Writes to unmapped indexes leave the phase running.
      '{ROW_CSR, CSR_SPARE_LOW,  4'hF, 10'd0, 1'b0, 1'b0, 16'd0},
      '{ROW_CSR, CSR_SPARE_HIGH, 4'h0, 10'd0, 1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd300,  1'b0, 1'b0, 16'd0},
      // Out-of-range selection falls back to the last entry.
      '{ROW_CSR, stpwm_pkg::CSR_PERIOD_SELECT, 4'hF, 10'd0, 1'b0, 1'b0, 16'd0},
      '{ROW_TICK, 2'd0, 4'd0, 10'd600,  1'b1, 1'b0, 16'd4}
   };

   // Ports of the block; every input starts at a known value.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [POWER_W-1:0]   req_power = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_drive;
   logic [PHASE_W-1:0]   rsp_phase_left;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // Predictor state and configuration.
   logic                cfg_mode;
   logic [SELECT_W-1:0] cfg_select;
   logic                pwm_level;
   int unsigned         ms_left;
   int unsigned         ms_interval;

   pwm_result_type drive_queue [$];
   pwm_result_type oldest_drive;

   int unsigned mismatch_count = 0;
   int unsigned responses_seen = 0;
   int unsigned ticks_sent = 0;
   int unsigned csr_writes = 0;
   int unsigned settings_run = 0;
   int unsigned input_stalls = 0;
   int unsigned burst_left = 0;
   bit          held_off = 1'b0;

   slow_time_proportioning_pwm uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_power      (req_power),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_drive      (rsp_drive),
      .rsp_phase_left (rsp_phase_left),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Free-running clock.
   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the handshakes lock up.
   initial begin
      #(LIMIT_NS);
      $display("%0t: timeout with %0d responses still expected", $time, drive_queue.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Period in milliseconds for a selection; high selections take the last entry.
   function automatic int unsigned period_ms(input logic [SELECT_W-1:0] sel);
      case (sel)
         4'd0:    return 100;
         4'd1:    return 200;
         4'd2:    return 500;
         4'd3:    return 1000;
         4'd4:    return 2000;
         4'd5:    return 5000;
         4'd6:    return 10000;
         4'd7:    return 20000;
         4'd8:    return 50000;
         default: return 5;
      endcase
   endfunction

   // A write to the mode or period-select register restarts the output low for one full period.
   function automatic void restart_low();
      pwm_level   = 1'b0;
      ms_interval = period_ms(cfg_select);
      ms_left     = ms_interval;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] index,
                                     input logic [CSR_DAT_W-1:0] data);
      if (index == stpwm_pkg::CSR_OUTPUT_MODE) begin
         cfg_mode = data[0];
      end else if (index == stpwm_pkg::CSR_PERIOD_SELECT) begin
         cfg_select = data;
      end else begin
         return;
      end
      restart_low();
   endfunction

   // One millisecond tick: advance the phase counter and work out the output.
   function automatic pwm_result_type advance_pwm(input logic [POWER_W-1:0] power);
      int unsigned pw;
      int unsigned per;
      int unsigned on_ms;
      int unsigned off_ms;
      int unsigned alt_ms;
      pwm_result_type res;
      pw = (power > FULL) ? FULL : power;
      if (!cfg_mode) begin
         pwm_level      = (pw != 0);
         res.drive      = pwm_level;
         res.phase_left = '0;
         return res;
      end
      if (ms_left <= 1) begin
         per   = period_ms(cfg_select);
         on_ms = per * pw / FULL;
         if (pwm_level) begin
            // Off time is the longer of the two roundings; full power keeps the level.
            if (pw != FULL) begin
               off_ms = per * (FULL - pw) / FULL;
               alt_ms = per - on_ms;
               if (alt_ms > off_ms) begin
                  off_ms = alt_ms;
               end
               if (off_ms != 0) begin
                  pwm_level   = 1'b0;
                  ms_interval = off_ms & 16'hFFFF;
               end
            end
         end else if (pw != 0 && on_ms != 0) begin
            pwm_level   = 1'b1;
            ms_interval = on_ms & 16'hFFFF;
         end
         ms_left = ms_interval;
      end else begin
         ms_left = ms_left - 1;
      end
      res.drive      = pwm_level;
      res.phase_left = ms_left[PHASE_W-1:0];
      return res;
   endfunction

   // Offer one request in bursts with random gaps; valid stays up across a burst.
   task automatic send_tick(input logic [POWER_W-1:0] power, input logic typed,
                            input pwm_result_type typed_result);
      int unsigned gap;
      pwm_result_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_power <= power;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_pwm(power);
      drive_queue.push_back(typed ? typed_result : predicted);
      ticks_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding response.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (drive_queue.size() != 0) @(negedge clock);
   endtask

   // Register write on the idle block; called at a falling edge.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DAT_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      apply_csr(index, data);
      csr_writes++;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Power for a steady stretch of ticks, drawn from one of several classes.
   function automatic logic [POWER_W-1:0] pick_power(input int unsigned kind);
      case (kind)
         0:       return '0;
         1:       return POWER_W'(FULL);
         2:       return POWER_W'($urandom_range(FULL + 1, 1023));
         3:       return POWER_W'($urandom_range(1, 199));
         4:       return POWER_W'($urandom_range(200, FULL - 1));
         default: return POWER_W'($urandom_range(0, 1023));
      endcase
   endfunction

   // Receiver: ready stretches, random stalls, and a long hold-off that fills the pipeline.
   // The hold-off is tried again until it has stalled the input at least once.
   initial begin : receiver
      int unsigned seg_kind;
      int unsigned seg_len;
      int unsigned stalls_before;
      forever begin
         seg_kind = $urandom_range(0, 9);
         seg_len  = (seg_kind < 8) ? $urandom_range(10, 50) : $urandom_range(1, 8);
         repeat (seg_len) begin
            @(negedge clock);
            if (!held_off && responses_seen >= HOLD_AFTER && req_valid) begin
               stalls_before = input_stalls;
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               rsp_ready <= 1'b1;
               held_off = (input_stalls > stalls_before);
            end else if (seg_kind < 4) begin
               rsp_ready <= 1'b1;
            end else if (seg_kind < 8) begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end else begin
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   // Response checker against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready) begin
         input_stalls++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (drive_queue.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual drive=%0b phase_left=%0d",
                     $time, rsp_drive, rsp_phase_left);
            mismatch_count++;
         end else begin
            oldest_drive = drive_queue.pop_front();
            if (rsp_drive !== oldest_drive.drive) begin
               $display("%0t: drive mismatch: expected %0b, actual %0b",
                        $time, oldest_drive.drive, rsp_drive);
               mismatch_count++;
            end
            if (rsp_phase_left !== oldest_drive.phase_left) begin
               $display("%0t: phase_left mismatch: expected %0d, actual %0d",
                        $time, oldest_drive.phase_left, rsp_phase_left);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, random settings and ticks, drain, verdict.
   initial begin : stimulus
      int unsigned row;
      int unsigned random_ticks;
      int unsigned stretch;
      int unsigned sel_pick;
      int unsigned power_kind;
      logic [POWER_W-1:0]   base_power;
      logic [POWER_W-1:0]   power;
      logic [SELECT_W-1:0]  sel;
      logic [CSR_DAT_W-1:0] mode_data;
      cfg_mode   = 1'b0;
      cfg_select = '0;
      restart_low();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table.
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (directed_rows[row].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed_rows[row].index, directed_rows[row].data);
         end else begin
            send_tick(directed_rows[row].power, directed_rows[row].typed,
                      {directed_rows[row].exp_drive, directed_rows[row].exp_phase});
         end
      end

      // Random settings, each followed by a stretch of ticks.
      random_ticks = 0;
      while (random_ticks < RANDOM_TICKS) begin
         wait_idle();
         sel_pick = $urandom_range(0, 19);
         if (sel_pick < 10) begin
            sel = SELECT_W'($urandom_range(9, 15));
         end else if (sel_pick < 16) begin
            sel = SELECT_W'($urandom_range(0, 1));
         end else if (sel_pick < 19) begin
            sel = SELECT_W'($urandom_range(2, 3));
         end else begin
            sel = SELECT_W'($urandom_range(4, 8));
         end
         mode_data    = CSR_DAT_W'($urandom_range(0, 15));
         mode_data[0] = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 1) == 0) begin
            write_csr(stpwm_pkg::CSR_PERIOD_SELECT, sel);
            write_csr(stpwm_pkg::CSR_OUTPUT_MODE, mode_data);
         end else begin
            write_csr(stpwm_pkg::CSR_OUTPUT_MODE, mode_data);
            write_csr(stpwm_pkg::CSR_PERIOD_SELECT, sel);
         end
         if ($urandom_range(0, 3) == 0) begin
            write_csr($urandom_range(0, 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH,
                      CSR_DAT_W'($urandom_range(0, 15)));
         end
         settings_run++;

         // Short periods get long stretches so that many phases expire.
         stretch    = (period_ms(cfg_select) <= 200) ? $urandom_range(40, 120)
                                                     : $urandom_range(20, 40);
         power_kind = $urandom_range(0, 5);
         base_power = pick_power(power_kind);
         repeat (stretch) begin
            if ($urandom_range(0, 9) == 0) begin
               power_kind = $urandom_range(0, 5);
               base_power = pick_power(power_kind);
            end
            power = ($urandom_range(0, 4) == 0) ? POWER_W'($urandom_range(0, 1023))
                                                : base_power;
            send_tick(power, 1'b0, '0);
            random_ticks++;
         end
      end

      // Drain and report.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d random settings with %0d register writes.",
               ticks_sent, settings_run, csr_writes);
      $display("Checked %0d responses; the input was stalled on %0d cycles.",
               responses_seen, input_stalls);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
